@@ hdl/tmf_pkg.sv @@
// Package for the trimmed-mean sample filter.
// Burst geometry, derived widths, queue entry and status types, back-end states.
// No dependencies.
`default_nettype none

package tmf_pkg;

	localparam int KEPT_COUNT  = 8;
	localparam int DROP_COUNT  = 4;
	localparam int SAMPLE_BITS = 10;
	localparam int AVG_SHIFT   = 3;
	localparam int OUT_BITS    = 10;

	localparam int BURST_LEN = KEPT_COUNT + DROP_COUNT;
	localparam int TRIM_LO   = DROP_COUNT / 2;
	localparam int TRIM_HI   = BURST_LEN - DROP_COUNT / 2 - 1;
	localparam int CNT_BITS  = $clog2(BURST_LEN + 1);
	localparam int IDX_BITS  = (BURST_LEN > 1) ? $clog2(BURST_LEN) : 1;
	localparam int SUM_BITS  = SAMPLE_BITS + $clog2(BURST_LEN + 1);

	localparam int QDEPTH     = 4;
	localparam int QPTR_BITS  = $clog2(QDEPTH);
	localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

	localparam logic [SUM_BITS-1:0] SAMPLE_MAX = SUM_BITS'((1 << SAMPLE_BITS) - 1);

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] smp;
		logic                   last;
	} tmf_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} tmf_qstat_t;

	typedef enum logic {
		BK_IDLE,
		BK_SUM
	} tmf_bk_state_t;

endpackage

`default_nettype wire

@@ hdl/trimmed_mean_sample_filter_unit.sv @@
// Trimmed-mean sample filter: bursts of twelve samples, the two lowest and two
// highest dropped, the middle eight averaged. Samples are taken on start && !busy.
// done pulses once the last sample of a burst has passed the queue, been inserted
// and the eight serial adds are through; later if the queue is backed up.
// Throughput: one sample per cycle within a burst; the serial sum at burst end
// stalls the back end and busy rises once the four-entry queue fills.
// Reset clears burst count, queue and state; the done strobe cannot be held off.
`default_nettype none

module trimmed_mean_sample_filter_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [9:0] sample,
	output logic            done,
	output logic [9:0]      average
);
	import tmf_pkg::*;

	tmf_qstat_t qstat;
	tmf_entry_t push_entry;
	tmf_entry_t head;
	logic       push;
	logic       pop;

	tmf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.sample     (sample),
		.qstat      (qstat),
		.busy       (busy),
		.push       (push),
		.push_entry (push_entry)
	);

	tmf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	tmf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.qstat   (qstat),
		.pop     (pop),
		.done    (done),
		.average (average)
	);

endmodule

`default_nettype wire

@@ hdl/tmf_front.sv @@
// Front end: takes sample requests, counts the burst and tags its last sample.
// Depends on tmf_pkg.
`default_nettype none

module tmf_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [9:0]                     sample,
	input  wire tmf_pkg::tmf_qstat_t            qstat,
	output logic                                busy,
	output logic                                push,
	output tmf_pkg::tmf_entry_t                 push_entry
);
	import tmf_pkg::*;

	logic [CNT_BITS-1:0] cnt_q;
	logic                last;

	assign busy  = qstat.full;
	assign push  = start && !qstat.full;
	assign last  = (cnt_q == CNT_BITS'(BURST_LEN - 1));

	assign push_entry.smp  = SAMPLE_BITS'(sample);
	assign push_entry.last = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push) begin
			cnt_q <= last ? '0 : cnt_q + 1'b1;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_BITS'(BURST_LEN))
		else $error("burst count out of range");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("push into full queue");
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(push && last) |=> (cnt_q == '0))
		else $error("burst count did not wrap");

endmodule

`default_nettype wire

@@ hdl/tmf_queue.sv @@
// Short register queue between front and back ends.
// Depends on tmf_pkg.
`default_nettype none

module tmf_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire tmf_pkg::tmf_entry_t push_entry,
	input  wire logic                pop,
	output tmf_pkg::tmf_entry_t      head,
	output tmf_pkg::tmf_qstat_t      qstat
);
	import tmf_pkg::*;

	tmf_entry_t           mem_q [QDEPTH];
	logic [QPTR_BITS-1:0] wr_q;
	logic [QPTR_BITS-1:0] rd_q;
	logic [QCNT_BITS-1:0] cnt_q;

	assign qstat.full  = (cnt_q == QCNT_BITS'(QDEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign head        = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> !qstat.full)
		else $error("push into full queue");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue count lost a push");

endmodule

`default_nettype wire

@@ hdl/tmf_back.sv @@
// Back end: insertion ranking into a sorted cell row, then serial sum of the
// kept middle, shift and saturate. Depends on tmf_pkg.
`default_nettype none

module tmf_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tmf_pkg::tmf_entry_t head,
	input  wire tmf_pkg::tmf_qstat_t qstat,
	output logic                     pop,
	output logic                     done,
	output logic [9:0]               average
);
	import tmf_pkg::*;

	tmf_bk_state_t state_q, state_nx;

	logic [SAMPLE_BITS-1:0] row_q   [BURST_LEN];
	logic [SAMPLE_BITS-1:0] row_nx  [BURST_LEN];
	logic [BURST_LEN-1:0]   gt;
	logic [CNT_BITS-1:0]    fill_q;
	logic [IDX_BITS-1:0]    idx_q;
	logic [SUM_BITS-1:0]    acc_q;
	logic [SUM_BITS-1:0]    sum_nx;
	logic [SUM_BITS-1:0]    mean;
	logic                   sum_en;
	logic                   finish;
	logic                   done_q;
	logic [OUT_BITS-1:0]    avg_q;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			BK_IDLE: if (!qstat.empty && head.last) state_nx = BK_SUM;
			BK_SUM:  if (idx_q == IDX_BITS'(TRIM_HI)) state_nx = BK_IDLE;
			default: state_nx = BK_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop    = 1'b0;
		sum_en = 1'b0;
		finish = 1'b0;
		unique case (state_q)
			BK_IDLE: pop = !qstat.empty;
			BK_SUM: begin
				sum_en = 1'b1;
				finish = (idx_q == IDX_BITS'(TRIM_HI));
			end
			default: ;
		endcase
	end

	// sorted insert: cells above the key move up one place
	always_comb begin
		for (int i = 0; i < BURST_LEN; i++) begin
			gt[i] = (CNT_BITS'(i) < fill_q) && (row_q[i] > head.smp);
		end
		for (int i = 0; i < BURST_LEN; i++) begin
			row_nx[i] = row_q[i];
			if (CNT_BITS'(i) <= fill_q) begin
				if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
					row_nx[i] = row_q[(i > 0) ? i - 1 : 0];
				end else if (gt[i] || CNT_BITS'(i) == fill_q) begin
					row_nx[i] = head.smp;
				end
			end
		end
	end

	assign sum_nx = acc_q + SUM_BITS'(row_q[idx_q]);
	assign mean   = sum_nx >> AVG_SHIFT;

	always_ff @(posedge clk) begin
		if (pop) begin
			row_q <= row_nx;
		end
		if (pop && head.last) begin
			acc_q <= '0;
			idx_q <= IDX_BITS'(TRIM_LO);
		end else if (sum_en) begin
			acc_q <= sum_nx;
			idx_q <= idx_q + 1'b1;
		end
		if (finish) begin
			avg_q <= OUT_BITS'((mean > SAMPLE_MAX) ? SAMPLE_MAX : mean);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			fill_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= finish;
			if (pop) begin
				fill_q <= head.last ? '0 : fill_q + 1'b1;
			end
		end
	end

	assign done    = done_q;
	assign average = avg_q;

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe longer than one cycle");
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < CNT_BITS'(BURST_LEN))
		else $error("fill count out of range");
	a_no_pop_in_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SUM) |-> !pop)
		else $error("queue popped during summation");
	a_last_at_full: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.last) |-> (fill_q == CNT_BITS'(BURST_LEN - 1)))
		else $error("burst end tag out of step with fill count");

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Testbench for trimmed_mean_sample_filter_unit: sends bursts of samples and checks
// each trimmed mean against a local sort-and-average model of the filter.
// Depends on hdl/tmf_pkg.sv and hdl/trimmed_mean_sample_filter_unit.sv.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import tmf_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_TOP = '1;

	logic                   clk    = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start  = 1'b0;
	logic [SAMPLE_BITS-1:0] sample = '0;
	logic                   busy;
	logic                   done;
	logic [OUT_BITS-1:0]    average;

	logic [SAMPLE_BITS-1:0] burst_held[$];
	logic [OUT_BITS-1:0]    mean_expected[$];
	int                     idle_pct = 0;
	int                     errors   = 0;
	int                     cycles   = 0;

	trimmed_mean_sample_filter_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.sample  (sample),
		.done    (done),
		.average (average)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d means still pending", $time, mean_expected.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// rank the burst, drop the extremes at both ends, average the middle
	function automatic logic [OUT_BITS-1:0] trimmed_mean(input logic [SAMPLE_BITS-1:0] held[$]);
		logic [SAMPLE_BITS-1:0] ranked[$];
		logic [SAMPLE_BITS-1:0] key;
		int                     j;
		int unsigned            sum;
		int unsigned            mean;
		ranked = held;
		sum = 0;
		for (int i = 1; i < ranked.size(); i++) begin
			key = ranked[i];
			j = i - 1;
			while (j >= 0 && ranked[j] > key) begin
				ranked[j + 1] = ranked[j];
				j--;
			end
			ranked[j + 1] = key;
		end
		for (int k = TRIM_LO; k <= TRIM_HI; k++)
			sum += ranked[k];
		mean = sum >> AVG_SHIFT;
		if (mean > SAMPLE_TOP)
			mean = SAMPLE_TOP;
		return mean[OUT_BITS-1:0];
	endfunction

	// one request; called and returns in the time step of a rising edge
	task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
		bit taken;
		while ($urandom_range(99) < idle_pct) begin
			start  <= 1'b0;
			sample <= SAMPLE_BITS'($urandom);
			@(posedge clk);
		end
		start  <= 1'b1;
		sample <= value;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		burst_held.push_back(value);
		if (burst_held.size() == BURST_LEN) begin
			mean_expected.push_back(trimmed_mean(burst_held));
			burst_held.delete();
		end
	endtask

	// done is registered; look at it mid-cycle
	always @(negedge clk) begin
		logic [OUT_BITS-1:0] want;
		if (arst_n && done) begin
			if (mean_expected.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %0d", $time, average);
			end else begin
				want = mean_expected.pop_front();
				if (average !== want) begin
					errors++;
					$display("%0t: average mismatch, expected %0d, actual %0d",
						$time, want, average);
				end
			end
		end
	end

	task automatic test_extreme_bursts();
		// outliers at both ends must be dropped, leaving the middle value
		send_sample('0);
		send_sample(SAMPLE_TOP);
		for (int k = 0; k < 4; k++)
			send_sample(SAMPLE_BITS'(512));
		send_sample('0);
		send_sample(SAMPLE_BITS'(512));
		send_sample(SAMPLE_BITS'(512));
		send_sample(SAMPLE_TOP);
		send_sample(SAMPLE_BITS'(512));
		send_sample(SAMPLE_BITS'(512));
		// full scale everywhere: largest sum
		for (int k = 0; k < BURST_LEN; k++)
			send_sample(SAMPLE_TOP);
	endtask

	task automatic test_random_bursts(input int bursts);
		int                     style;
		logic [SAMPLE_BITS-1:0] base;
		logic [SAMPLE_BITS-1:0] value;
		for (int b = 0; b < bursts; b++) begin
			style = $urandom_range(3);
			base  = SAMPLE_BITS'($urandom);
			for (int k = 0; k < BURST_LEN; k++) begin
				case (style)
					0: value = SAMPLE_BITS'($urandom);
					1: value = base ^ SAMPLE_BITS'($urandom_range(15));
					2: value = $urandom_range(1) ? SAMPLE_TOP : '0;
					default: begin
						// tight cluster with the odd rail-to-rail spike
						if ($urandom_range(5) == 0)
							value = $urandom_range(1) ? SAMPLE_TOP : '0;
						else
							value = base ^ SAMPLE_BITS'($urandom_range(7));
					end
				endcase
				send_sample(value);
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 33;
		test_extreme_bursts();
		test_random_bursts(45);
		idle_pct = 71;
		test_random_bursts(45);
		idle_pct = 0;
		test_random_bursts(44);

		start  <= 1'b0;
		sample <= '0;
		while (mean_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/tmf_pkg.sv
hdl/tmf_front.sv
hdl/tmf_queue.sv
hdl/tmf_back.sv
hdl/trimmed_mean_sample_filter_unit.sv
verif/testbench.sv
